// ===== hdl/bps_pkg.sv =====
`default_nettype none

package bps_pkg;

    // Coordinate and counter widths.
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 24;
    localparam int SUM_BITS   = COORD_BITS + COUNT_BITS;
    localparam int MEAN_BITS  = COORD_BITS + 1;
    localparam int STEP_BITS  = $clog2(COORD_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [MEAN_BITS-1:0]  MEAN_EMPTY = {MEAN_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0]  STEP_LAST  = STEP_BITS'(COORD_BITS - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic load_x;
        logic load_y;
        logic step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/bps_ctrl.sv =====
`default_nettype none

module bps_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_last,
    input  bps_pkg::t_status    i_status,
    output logic                o_in_ready,
    output bps_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADX = 3'd1;
    localparam logic [2:0] S_DIVX  = 3'd2;
    localparam logic [2:0] S_LOADY = 3'd3;
    localparam logic [2:0] S_DIVY  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [bps_pkg::STEP_BITS-1:0] r_step;
    logic [bps_pkg::STEP_BITS-1:0] n_step;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_last) begin
                        n_state = S_LOADX;
                    end
                end
            end
            S_LOADX: begin
                if (i_status.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.load_x = 1'b1;
                    n_step       = '0;
                    n_state      = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == bps_pkg::STEP_LAST) begin
                    n_state = S_LOADY;
                end
            end
            S_LOADY: begin
                o_cmd.load_y = 1'b1;
                n_step       = '0;
                n_state      = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == bps_pkg::STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bps_dp.sv =====
`default_nettype none

module bps_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  bps_pkg::t_cmd                        i_cmd,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_point_x,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_point_y,
    input  wire                                  i_has_point,
    input  wire                                  i_out_ready,
    output bps_pkg::t_status                     o_status,
    output logic                                 o_out_valid,
    output logic signed [bps_pkg::MEAN_BITS-1:0] o_mean_x,
    output logic signed [bps_pkg::MEAN_BITS-1:0] o_mean_y,
    output logic signed [bps_pkg::MEAN_BITS-1:0] o_signed_width,
    output logic [bps_pkg::COORD_BITS-1:0]       o_blob_height,
    output logic [bps_pkg::COUNT_BITS-1:0]       o_point_count
);

    localparam int CB = bps_pkg::COORD_BITS;
    localparam int NB = bps_pkg::COUNT_BITS;
    localparam int SB = bps_pkg::SUM_BITS;
    localparam int MB = bps_pkg::MEAN_BITS;

    logic [SB-1:0] r_sum_x;
    logic [SB-1:0] r_sum_y;
    logic [NB-1:0] r_count;
    logic [CB-1:0] r_left_x;
    logic [CB-1:0] r_left_y;
    logic [CB-1:0] r_right_x;
    logic [CB-1:0] r_right_y;
    logic [CB-1:0] r_min_row;
    logic [CB-1:0] r_max_row;

    logic [NB-1:0] r_rem;
    logic [CB-1:0] r_dvd;
    logic [CB-1:0] r_quo;
    logic [CB-1:0] r_mean_x;

    logic          r_out_valid;
    logic [MB-1:0] r_out_mean_x;
    logic [MB-1:0] r_out_mean_y;
    logic [MB-1:0] r_out_width;
    logic [CB-1:0] r_out_height;
    logic [NB-1:0] r_out_count;

    logic          accept_pt;
    logic          first_pt;
    logic [NB:0]   trial;
    logic          q_bit;
    logic [MB-1:0] diff;
    logic [MB-1:0] width;
    logic          empty;

    assign empty           = (r_count == '0);
    assign o_status.empty  = empty;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // A point is dropped once the count is full.
    assign accept_pt = i_cmd.take && i_has_point && (r_count != bps_pkg::COUNT_MAX);
    assign first_pt  = empty;

    // Point accumulation and extremes; cleared once a result is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_count   <= '0;
            r_left_x  <= '0;
            r_left_y  <= '0;
            r_right_x <= '0;
            r_right_y <= '0;
            r_min_row <= '0;
            r_max_row <= '0;
        end else if (accept_pt) begin
            r_sum_x <= r_sum_x + SB'(i_point_x);
            r_sum_y <= r_sum_y + SB'(i_point_y);
            r_count <= r_count + 1'b1;
            if (first_pt || i_point_x < r_left_x) begin
                r_left_x <= i_point_x;
                r_left_y <= i_point_y;
            end
            if (first_pt || i_point_x > r_right_x) begin
                r_right_x <= i_point_x;
                r_right_y <= i_point_y;
            end
            if (first_pt || i_point_y < r_min_row) begin
                r_min_row <= i_point_y;
            end
            if (first_pt || i_point_y > r_max_row) begin
                r_max_row <= i_point_y;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle. The mean fits in
    // COORD_BITS bits, so the upper part of the sum is already below the count.
    assign trial = {r_rem, r_dvd[CB-1]};
    assign q_bit = (trial >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_rem <= r_sum_x[SB-1:CB];
            r_dvd <= r_sum_x[CB-1:0];
        end else if (i_cmd.load_y) begin
            r_rem    <= r_sum_y[SB-1:CB];
            r_dvd    <= r_sum_y[CB-1:0];
            r_mean_x <= r_quo;
        end else if (i_cmd.step) begin
            r_rem <= q_bit ? NB'(trial - {1'b0, r_count}) : trial[NB-1:0];
            r_dvd <= {r_dvd[CB-2:0], 1'b0};
            r_quo <= {r_quo[CB-2:0], q_bit};
        end
    end

    // Width sign follows the tilt of the extreme points.
    assign diff  = {1'b0, r_right_x} - {1'b0, r_left_x};
    assign width = (r_right_y > r_left_y) ? diff : MB'(-diff);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_mean_x <= empty ? bps_pkg::MEAN_EMPTY : {1'b0, r_mean_x};
            r_out_mean_y <= empty ? bps_pkg::MEAN_EMPTY : {1'b0, r_quo};
            r_out_width  <= width;
            r_out_height <= r_max_row - r_min_row;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mean_x       = r_out_mean_x;
    assign o_mean_y       = r_out_mean_y;
    assign o_signed_width = r_out_width;
    assign o_blob_height  = r_out_height;
    assign o_point_count  = r_out_count;

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before it was taken");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.load_x || i_cmd.load_y || i_cmd.step) && !empty) |-> (r_rem < r_count))
        else $error("divider remainder out of range");

    // An empty blob reports means of minus one.
    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && empty) |=> (r_out_mean_x == bps_pkg::MEAN_EMPTY
                                     && r_out_mean_y == bps_pkg::MEAN_EMPTY))
        else $error("empty blob mean is not minus one");

endmodule

`default_nettype wire

// ===== hdl/blob_point_statistics.sv =====
// Points are taken one per cycle while the block is idle; items without last give no result.
// An item with last gives its result through the shared bit-serial divider, which computes
// mean x and then mean y; an empty blob skips the divider.
// A finished result waits in the output register while new points are taken.
// Reset (synchronous, active low) clears all sums, extremes, the count and the output valid.
`default_nettype none

module blob_point_statistics (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_point_x,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_point_y,
    input  wire                                  i_has_point,
    input  wire                                  i_last,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [bps_pkg::MEAN_BITS-1:0] o_mean_x,
    output logic signed [bps_pkg::MEAN_BITS-1:0] o_mean_y,
    output logic signed [bps_pkg::MEAN_BITS-1:0] o_signed_width,
    output logic [bps_pkg::COORD_BITS-1:0]       o_blob_height,
    output logic [bps_pkg::COUNT_BITS-1:0]       o_point_count
);

    bps_pkg::t_cmd    cmd;
    bps_pkg::t_status status;

    // Sequencer.
    bps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Accumulators, divider and output register.
    bps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_has_point    (i_has_point),
        .i_out_ready    (i_out_ready),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_mean_x       (o_mean_x),
        .o_mean_y       (o_mean_y),
        .o_signed_width (o_signed_width),
        .o_blob_height  (o_blob_height),
        .o_point_count  (o_point_count)
    );

endmodule

`default_nettype wire

// ===== sim/blob_stats_monitor.sv =====
`timescale 1ns / 100ps

// Watches both channels of the blob statistics block, predicts the summary of each blob
// from the accepted point items and compares every accepted result with the oldest one due.
module blob_stats_monitor (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  i_in_ready,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_point_x,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_point_y,
    input  wire                                  i_has_point,
    input  wire                                  i_last,
    input  wire                                  i_out_valid,
    input  wire                                  i_out_ready,
    input  wire signed [bps_pkg::MEAN_BITS-1:0]  i_mean_x,
    input  wire signed [bps_pkg::MEAN_BITS-1:0]  i_mean_y,
    input  wire signed [bps_pkg::MEAN_BITS-1:0]  i_signed_width,
    input  wire [bps_pkg::COORD_BITS-1:0]        i_blob_height,
    input  wire [bps_pkg::COUNT_BITS-1:0]        i_point_count,
    output int                                   o_pending,
    output int                                   o_fail_count
);

    localparam int CB = bps_pkg::COORD_BITS;
    localparam int NB = bps_pkg::COUNT_BITS;
    localparam int SB = bps_pkg::SUM_BITS;
    localparam int MB = bps_pkg::MEAN_BITS;

    typedef struct packed {
        logic signed [MB-1:0] mean_x;
        logic signed [MB-1:0] mean_y;
        logic signed [MB-1:0] signed_width;
        logic [CB-1:0]        blob_height;
        logic [NB-1:0]        point_count;
    } t_blob_summary;

    // Running statistics of the blob being gathered.
    logic [SB-1:0] acc_x;
    logic [SB-1:0] acc_y;
    logic [NB-1:0] n_points;
    logic [CB-1:0] left_col;
    logic [CB-1:0] left_row;
    logic [CB-1:0] right_col;
    logic [CB-1:0] right_row;
    logic [CB-1:0] row_lo;
    logic [CB-1:0] row_hi;

    t_blob_summary pending_summaries[$];
    int            mismatches = 0;

    task clear_blob();
        acc_x     = '0;
        acc_y     = '0;
        n_points  = '0;
        left_col  = '0;
        left_row  = '0;
        right_col = '0;
        right_row = '0;
        row_lo    = '0;
        row_hi    = '0;
    endtask

    // A point is dropped whole once the count is full, so the sums never wrap.
    task absorb_point(input logic [CB-1:0] x, input logic [CB-1:0] y);
        if (n_points != bps_pkg::COUNT_MAX) begin
            if (n_points == '0) begin
                left_col  = x;
                left_row  = y;
                right_col = x;
                right_row = y;
                row_lo    = y;
                row_hi    = y;
            end else begin
                // Strict compares keep the first point met on a tie.
                if (x < left_col) begin
                    left_col = x;
                    left_row = y;
                end
                if (x > right_col) begin
                    right_col = x;
                    right_row = y;
                end
                if (y < row_lo) row_lo = y;
                if (y > row_hi) row_hi = y;
            end
            acc_x    = acc_x + SB'(x);
            acc_y    = acc_y + SB'(y);
            n_points = n_points + 1'b1;
        end
    endtask

    // Forms the summary of the finished blob and starts a new one.
    task close_blob();
        t_blob_summary summary;
        logic [MB-1:0] span;
        if (n_points == '0) begin
            summary.mean_x       = bps_pkg::MEAN_EMPTY;
            summary.mean_y       = bps_pkg::MEAN_EMPTY;
            summary.signed_width = '0;
            summary.blob_height  = '0;
            summary.point_count  = '0;
        end else begin
            summary.mean_x = MB'(acc_x / SB'(n_points));
            summary.mean_y = MB'(acc_y / SB'(n_points));
            span = {1'b0, right_col} - {1'b0, left_col};
            // The width is positive only when the rightmost point sits on a higher row.
            summary.signed_width = (right_row > left_row) ? span : -span;
            summary.blob_height  = row_hi - row_lo;
            summary.point_count  = n_points;
        end
        pending_summaries = {pending_summaries, summary};
        clear_blob();
    endtask

    task check_result();
        t_blob_summary due;
        t_blob_summary seen;
        seen = '{i_mean_x, i_mean_y, i_signed_width, i_blob_height, i_point_count};
        if (pending_summaries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: mean_x %0d mean_y %0d width %0d height %0d count %0d",
                         seen.mean_x, seen.mean_y, seen.signed_width, seen.blob_height,
                         seen.point_count);
        end else begin
            due = pending_summaries.pop_front();
            if (seen != due) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch at %0t:", $realtime);
                    $display("  expected mean_x %0d mean_y %0d width %0d height %0d count %0d",
                             due.mean_x, due.mean_y, due.signed_width, due.blob_height,
                             due.point_count);
                    $display("  actual   mean_x %0d mean_y %0d width %0d height %0d count %0d",
                             seen.mean_x, seen.mean_y, seen.signed_width, seen.blob_height,
                             seen.point_count);
                end
            end
        end
    endtask

    // Results are checked before the input item of the same edge is taken in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_blob();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                if (i_has_point) absorb_point(i_point_x, i_point_y);
                if (i_last) close_blob();
            end
        end
        o_pending    <= pending_summaries.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== sim/blob_point_statistics_test.sv =====
`timescale 1ns / 100ps

// Drives point items into the blob statistics block and gives the verdict.
module blob_point_statistics_test;

    localparam int CB = bps_pkg::COORD_BITS;
    localparam int NB = bps_pkg::COUNT_BITS;
    localparam int MB = bps_pkg::MEAN_BITS;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 235;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [CB-1:0]        i_point_x = '0;
    logic [CB-1:0]        i_point_y = '0;
    logic                 i_has_point = 1'b0;
    logic                 i_last = 1'b0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic signed [MB-1:0] o_mean_x;
    logic signed [MB-1:0] o_mean_y;
    logic signed [MB-1:0] o_signed_width;
    logic [CB-1:0]        o_blob_height;
    logic [NB-1:0]        o_point_count;

    int pending;
    int fail_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int items_sent = 0;

    blob_point_statistics uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_has_point    (i_has_point),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mean_x       (o_mean_x),
        .o_mean_y       (o_mean_y),
        .o_signed_width (o_signed_width),
        .o_blob_height  (o_blob_height),
        .o_point_count  (o_point_count)
    );

    blob_stats_monitor stats_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_has_point    (i_has_point),
        .i_last         (i_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_mean_x       (o_mean_x),
        .i_mean_y       (o_mean_y),
        .i_signed_width (o_signed_width),
        .i_blob_height  (o_blob_height),
        .i_point_count  (o_point_count),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Guard against a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("blob_point_statistics verification failed");
            $finish;
        end
    end

    // Offers one item, with random idle cycles first, and returns at the edge that takes it.
    task automatic offer_point(input logic [CB-1:0] x, input logic [CB-1:0] y,
                               input logic has, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_point_x   <= x;
        i_point_y   <= y;
        i_has_point <= has;
        i_last      <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Holds off the sender until every summary due has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Coordinates drawn to favor ties, the extremes or the whole range.
    function automatic logic [CB-1:0] pick_coord(input int style);
        case (style)
            0: pick_coord = CB'($urandom_range(0, 4095));
            1: pick_coord = CB'($urandom_range(0, 7));
            2: pick_coord = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: pick_coord = CB'($urandom_range(4088, 4095));
        endcase
    endfunction

    // One blob of random size and content; now and then an empty or point-less end.
    task automatic send_random_blob();
        int            len;
        int            style;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          has;
        if ($urandom_range(0, 24) == 0) begin
            offer_point(CB'($urandom), CB'($urandom), 1'b0, 1'b1);
            return;
        end
        style = $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(20, 60);
        else len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
            x   = pick_coord(style);
            y   = pick_coord($urandom_range(0, 1) ? style : 0);
            has = ($urandom_range(0, 9) != 0);
            offer_point(x, y, has, k == len - 1);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int goal;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = items_sent + n_items;
        while (items_sent < goal) send_random_blob();
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 53;

        // Empty blob, then single points at both corners.
        offer_point(12'd0, 12'd0, 1'b0, 1'b1);
        offer_point(12'd0, 12'd0, 1'b1, 1'b1);
        offer_point(12'hFFF, 12'hFFF, 1'b1, 1'b1);
        // Rightmost point on the higher row; the last item carries no point.
        offer_point(12'd10, 12'd20, 1'b1, 1'b0);
        offer_point(12'd30, 12'd50, 1'b1, 1'b0);
        offer_point(12'd77, 12'd99, 1'b0, 1'b1);
        // Rightmost point below the leftmost, the point on the last item.
        offer_point(12'd100, 12'd900, 1'b1, 1'b0);
        offer_point(12'hFFF, 12'd5, 1'b1, 1'b1);
        // Ties on both extremes keep the first point met; an idle item in between.
        offer_point(12'd50, 12'd10, 1'b1, 1'b0);
        offer_point(12'd50, 12'd99, 1'b1, 1'b0);
        offer_point(12'd200, 12'd7, 1'b1, 1'b0);
        offer_point(12'd3, 12'd3, 1'b0, 1'b0);
        offer_point(12'd200, 12'd300, 1'b1, 1'b0);
        offer_point(12'd120, 12'hFFF, 1'b1, 1'b1);
        // Equal rows give a negated width.
        offer_point(12'd5, 12'd60, 1'b1, 1'b0);
        offer_point(12'd4000, 12'd60, 1'b1, 1'b1);
        // Full spread in both tilts.
        offer_point(12'hFFF, 12'd0, 1'b1, 1'b0);
        offer_point(12'd0, 12'hFFF, 1'b1, 1'b1);
        offer_point(12'd0, 12'd0, 1'b1, 1'b0);
        offer_point(12'hFFF, 12'hFFF, 1'b1, 1'b1);
        // Largest means.
        offer_point(12'hFFF, 12'hFFF, 1'b1, 1'b0);
        offer_point(12'hFFF, 12'hFFF, 1'b1, 1'b1);
        drain_results();

        run_phase(35, 53, PHASE_ITEMS);
        run_phase(53, 35, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("blob_point_statistics verification clean");
        end else begin
            $display("blob_point_statistics verification failed");
        end
        $finish;
    end

endmodule
